@@ rtl/lsf_pkg.sv @@
// shared types, request codes and the fixed init table for the spi lcd framer
// used by every module under rtl; depends on nothing
package lsf_pkg;

    // request codes on the input selector
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_FULL   = 3'd1;
    localparam logic [2:0] CMD_WINDOW = 3'd2;
    localparam logic [2:0] CMD_PIXEL  = 3'd3;
    localparam logic [2:0] CMD_CLOSE  = 3'd4;

    // panel command bytes
    localparam logic [7:0] OP_SWRESET = 8'h01;
    localparam logic [7:0] OP_SLPOUT  = 8'h11;
    localparam logic [7:0] OP_COLMOD  = 8'h3a;
    localparam logic [7:0] OP_MADCTL  = 8'h36;
    localparam logic [7:0] OP_CASET   = 8'h2A;
    localparam logic [7:0] OP_RASET   = 8'h2B;
    localparam logic [7:0] OP_INVON   = 8'h21;
    localparam logic [7:0] OP_NORON   = 8'h13;
    localparam logic [7:0] OP_DISPON  = 8'h29;
    localparam logic [7:0] OP_RAMWR   = 8'h2C;
    localparam logic [7:0] PIX_565    = 8'h55;
    localparam logic [7:0] ROW_END    = 8'hf0;

    localparam int unsigned IDX_W      = 5;
    localparam logic [IDX_W-1:0] INIT_LAST = 5'd18;
    localparam logic [IDX_W-1:0] WIN_LAST  = 5'd10;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_LVL_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_FULL,
        KIND_WINDOW,
        KIND_PIXEL,
        KIND_CLOSE
    } kind_t;

    // classified request; window: p0 x, p1 end column, p2 y; pixel: p0 first, p1 second
    typedef struct packed {
        kind_t      kind;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] p2;
    } desc_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       is_data;
        logic       end_transfer;
        logic [4:0] wait_units;
        logic       last;
    } item_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_LVL_W-1:0] level;
    } q_stat_t;

    function automatic item_t mk_item(logic [7:0] b, logic dc, logic e, logic [4:0] w);
        item_t it;
        it.data_byte    = b;
        it.byte_valid   = 1'b1;
        it.is_data      = dc;
        it.end_transfer = e;
        it.wait_units   = w;
        it.last         = 1'b0;
        return it;
    endfunction

    function automatic item_t init_item(logic [IDX_W-1:0] idx);
        item_t it;
        unique case (idx)
            5'd0:    it = mk_item(OP_SWRESET, 1'b0, 1'b1, 5'd20);
            5'd1:    it = mk_item(OP_SLPOUT,  1'b0, 1'b1, 5'd10);
            5'd2:    it = mk_item(OP_COLMOD,  1'b0, 1'b0, 5'd0);
            5'd3:    it = mk_item(PIX_565,    1'b1, 1'b1, 5'd2);
            5'd4:    it = mk_item(OP_MADCTL,  1'b0, 1'b0, 5'd0);
            5'd5:    it = mk_item(8'h00,      1'b1, 1'b1, 5'd0);
            5'd6:    it = mk_item(OP_CASET,   1'b0, 1'b0, 5'd0);
            5'd7:    it = mk_item(8'h00,      1'b1, 1'b0, 5'd0);
            5'd8:    it = mk_item(8'h00,      1'b1, 1'b0, 5'd0);
            5'd9:    it = mk_item(8'h00,      1'b1, 1'b0, 5'd0);
            5'd10:   it = mk_item(ROW_END,    1'b1, 1'b1, 5'd0);
            5'd11:   it = mk_item(OP_RASET,   1'b0, 1'b0, 5'd0);
            5'd12:   it = mk_item(8'h00,      1'b1, 1'b0, 5'd0);
            5'd13:   it = mk_item(8'h00,      1'b1, 1'b0, 5'd0);
            5'd14:   it = mk_item(8'h00,      1'b1, 1'b0, 5'd0);
            5'd15:   it = mk_item(ROW_END,    1'b1, 1'b1, 5'd0);
            5'd16:   it = mk_item(OP_INVON,   1'b0, 1'b1, 5'd2);
            5'd17:   it = mk_item(OP_NORON,   1'b0, 1'b1, 5'd2);
            5'd18:   it = mk_item(OP_DISPON,  1'b0, 1'b1, 5'd2);
            default: it = mk_item(OP_DISPON,  1'b0, 1'b1, 5'd2);
        endcase
        it.last = (idx >= INIT_LAST);
        return it;
    endfunction

endpackage

@@ rtl/lcd_spi_command_framer.sv @@
// top level of the spi lcd command framer: front end, request queue, back end
// depends on lsf_pkg, lsf_front, lsf_queue, lsf_back
//
// channel   dir  tdata fields (low bit up)                           tuser / tlast
// s_axis    in   x[7:0] y[15:8] width[23:16] pixel[39:24] high_first[40]  tuser: cmd
// m_axis    out  data_byte[7:0] end_transfer[8] wait_units[13:9]      tuser: byte_valid,
//                                                                     is_data; tlast: last
//
// a request is taken every cycle while the 4-entry queue has room; unknown codes are dropped
// the back end sequencer sends one byte per cycle while a request is queued and the output
// is not stalled: pixel 2 bytes, window 11, init 19, full write and close one item each
// reset clears the queue pointers, the sequence index and the output valid
// an output stall holds the output register and the sequencer; the queue keeps filling

module lcd_spi_command_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // x, y, width, pixel, high_first, zero pad
    input  logic [2:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_byte, end_transfer, wait_units, zero pad
    output logic [1:0]  m_axis_tuser,   // byte_valid, is_data
    output logic        m_axis_tlast
);

    logic             legal;
    logic             push;
    logic             pop;
    lsf_pkg::desc_t   in_desc;
    lsf_pkg::desc_t   head;
    lsf_pkg::q_stat_t q_stat;
    lsf_pkg::item_t   out_item;

    lsf_front u_front (
        .cmd        (s_axis_tuser),
        .x          (s_axis_tdata[7:0]),
        .y          (s_axis_tdata[15:8]),
        .width      (s_axis_tdata[23:16]),
        .pixel      (s_axis_tdata[39:24]),
        .high_first (s_axis_tdata[40]),
        .legal      (legal),
        .desc       (in_desc)
    );

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && s_axis_tready && legal;

    lsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (in_desc),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    lsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_stat.empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = {2'b00, out_item.wait_units, out_item.end_transfer,
                           out_item.data_byte};
    assign m_axis_tuser = {out_item.is_data, out_item.byte_valid};
    assign m_axis_tlast = out_item.last;

`ifndef NO_ASSERTIONS
    // a taken legal request, close included, is in the queue the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("accepted request missing from queue");

    // a close marker always raises chip select and ends its request
    a_close_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_item.byte_valid) |->
        (out_item.end_transfer && out_item.is_data && out_item.last))
        else $error("malformed close marker");

    // delays only follow a byte that ends a transfer
    a_wait_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_item.wait_units != 5'd0)) |-> out_item.end_transfer)
        else $error("delay without end of transfer");
`endif

endmodule

@@ rtl/lsf_front.sv @@
// front end: classifies a request and prepares its queue entry
// depends on lsf_pkg
module lsf_front (
    input  logic [2:0]     cmd,
    input  logic [7:0]     x,
    input  logic [7:0]     y,
    input  logic [7:0]     width,
    input  logic [15:0]    pixel,
    input  logic           high_first,
    output logic           legal,
    output lsf_pkg::desc_t desc
);

    logic [7:0] end_col;

    assign end_col = x + width - 8'd1;

    always_comb
    begin
        legal     = 1'b1;
        desc.kind = lsf_pkg::KIND_CLOSE;
        desc.p0   = x;
        desc.p1   = end_col;
        desc.p2   = y;
        unique case (cmd)
            lsf_pkg::CMD_INIT:   desc.kind = lsf_pkg::KIND_INIT;
            lsf_pkg::CMD_FULL:   desc.kind = lsf_pkg::KIND_FULL;
            lsf_pkg::CMD_WINDOW: desc.kind = lsf_pkg::KIND_WINDOW;
            lsf_pkg::CMD_PIXEL:
            begin
                desc.kind = lsf_pkg::KIND_PIXEL;
                // byte order is fixed here so the back end just plays p0 then p1
                desc.p0   = high_first ? pixel[15:8] : pixel[7:0];
                desc.p1   = high_first ? pixel[7:0]  : pixel[15:8];
            end
            lsf_pkg::CMD_CLOSE:  desc.kind = lsf_pkg::KIND_CLOSE;
            default:             legal     = 1'b0;
        endcase
    end

endmodule

@@ rtl/lsf_queue.sv @@
// small request queue between front and back end
// depends on lsf_pkg
module lsf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lsf_pkg::desc_t    push_desc,
    input  logic              pop,
    output lsf_pkg::desc_t    head,
    output lsf_pkg::q_stat_t  stat
);

    lsf_pkg::desc_t                entry_reg [lsf_pkg::Q_DEPTH];
    logic [lsf_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lsf_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lsf_pkg::Q_LVL_W-1:0]   level_reg, level_next;
    logic                          do_push, do_pop;

    assign stat.full  = (level_reg == lsf_pkg::Q_LVL_W'(lsf_pkg::Q_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;
    assign head       = entry_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

@@ rtl/lsf_back.sv @@
// back end: walks the byte sequence of the queued request, one byte per cycle
// into the output register unless the output stalls; depends on lsf_pkg
module lsf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lsf_pkg::desc_t    head,
    input  logic              head_valid,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lsf_pkg::item_t    out_item
);

    logic [lsf_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    lsf_pkg::item_t            out_item_reg;
    lsf_pkg::item_t            cur;
    logic                      load, take;

    function automatic lsf_pkg::item_t seq_item(lsf_pkg::desc_t d,
                                                logic [lsf_pkg::IDX_W-1:0] idx);
        lsf_pkg::item_t it;
        it = lsf_pkg::mk_item(lsf_pkg::OP_RAMWR, 1'b0, 1'b0, 5'd0);
        case (d.kind)
            lsf_pkg::KIND_INIT:
            begin
                it = lsf_pkg::init_item(idx);
            end
            lsf_pkg::KIND_FULL:
            begin
                it.last = 1'b1;
            end
            lsf_pkg::KIND_WINDOW:
            begin
                unique case (idx)
                    5'd0:    it = lsf_pkg::mk_item(lsf_pkg::OP_CASET, 1'b0, 1'b0, 5'd0);
                    5'd1:    it = lsf_pkg::mk_item(8'h00, 1'b1, 1'b0, 5'd0);
                    5'd2:    it = lsf_pkg::mk_item(d.p0, 1'b1, 1'b0, 5'd0);
                    5'd3:    it = lsf_pkg::mk_item(8'h00, 1'b1, 1'b0, 5'd0);
                    5'd4:    it = lsf_pkg::mk_item(d.p1, 1'b1, 1'b1, 5'd0);
                    5'd5:    it = lsf_pkg::mk_item(lsf_pkg::OP_RASET, 1'b0, 1'b0, 5'd0);
                    5'd6:    it = lsf_pkg::mk_item(8'h00, 1'b1, 1'b0, 5'd0);
                    5'd7:    it = lsf_pkg::mk_item(d.p2, 1'b1, 1'b0, 5'd0);
                    5'd8:    it = lsf_pkg::mk_item(8'h00, 1'b1, 1'b0, 5'd0);
                    5'd9:    it = lsf_pkg::mk_item(lsf_pkg::ROW_END, 1'b1, 1'b1, 5'd0);
                    default: it = lsf_pkg::mk_item(lsf_pkg::OP_RAMWR, 1'b0, 1'b0, 5'd0);
                endcase
                it.last = (idx >= lsf_pkg::WIN_LAST);
            end
            lsf_pkg::KIND_PIXEL:
            begin
                it      = lsf_pkg::mk_item((idx == '0) ? d.p0 : d.p1, 1'b1, 1'b0, 5'd0);
                it.last = (idx != '0);
            end
            default:
            begin
                // close marker: dc goes up with chip select, no byte on the wire
                it.data_byte    = 8'h00;
                it.byte_valid   = 1'b0;
                it.is_data      = 1'b1;
                it.end_transfer = 1'b1;
                it.last         = 1'b1;
            end
        endcase
        return it;
    endfunction

    assign cur  = seq_item(head, idx_reg);
    assign load = !out_valid_reg || out_ready;
    assign take = load && head_valid;
    assign pop  = take && cur.last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            idx_next = cur.last ? '0 : idx_reg + 1'b1;
        end
        if (load)
        begin
            out_valid_next = head_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_item_reg <= cur;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ bench/tb.sv @@
// testbench for lcd_spi_command_framer: sends display requests on the input stream and
// checks every spi byte, close marker and tag against a frame predictor held in the bench
// depends on lsf_pkg and the framer rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
    localparam int IDLE_PCT      = 26;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  width;
        logic [15:0] pixel;
        logic        high_first;
    } lcd_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // x, y, width, pixel, high_first, zero pad
    logic [2:0]  s_axis_tuser = '0;    // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // data_byte, end_transfer, wait_units, zero pad
    logic [1:0]  m_axis_tuser;         // byte_valid, is_data
    logic        m_axis_tlast;

    lsf_pkg::item_t spi_bytes_due[$];
    int    mismatches = 0;
    int    requests_framed = 0;
    int    quiet_cycles = 0;
    bit    src_idle_on = 1'b1;
    bit    sink_idle_on = 1'b1;

    lcd_spi_command_framer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic void queue_byte(logic [7:0] b, logic dc, logic cs_up, logic [4:0] delay);
        lsf_pkg::item_t e;
        e.data_byte    = b;
        e.byte_valid   = 1'b1;
        e.is_data      = dc;
        e.end_transfer = cs_up;
        e.wait_units   = delay;
        e.last         = 1'b0;
        spi_bytes_due.push_back(e);
    endfunction

    // expected spi bytes for one request, appended in send order
    function automatic void frame_request(lcd_req_t r);
        int             queued;
        lsf_pkg::item_t tail;
        logic [7:0]     end_col;
        queued  = spi_bytes_due.size();
        end_col = r.x + r.width - 8'd1;
        case (r.cmd)
            lsf_pkg::CMD_INIT:
            begin
                queue_byte(lsf_pkg::OP_SWRESET, 1'b0, 1'b1, 5'd20);
                queue_byte(lsf_pkg::OP_SLPOUT,  1'b0, 1'b1, 5'd10);
                queue_byte(lsf_pkg::OP_COLMOD,  1'b0, 1'b0, 5'd0);
                queue_byte(lsf_pkg::PIX_565,    1'b1, 1'b1, 5'd2);
                queue_byte(lsf_pkg::OP_MADCTL,  1'b0, 1'b0, 5'd0);
                queue_byte(8'h00,               1'b1, 1'b1, 5'd0);
                queue_byte(lsf_pkg::OP_CASET,   1'b0, 1'b0, 5'd0);
                queue_byte(8'h00,               1'b1, 1'b0, 5'd0);
                queue_byte(8'h00,               1'b1, 1'b0, 5'd0);
                queue_byte(8'h00,               1'b1, 1'b0, 5'd0);
                queue_byte(lsf_pkg::ROW_END,    1'b1, 1'b1, 5'd0);
                queue_byte(lsf_pkg::OP_RASET,   1'b0, 1'b0, 5'd0);
                queue_byte(8'h00,               1'b1, 1'b0, 5'd0);
                queue_byte(8'h00,               1'b1, 1'b0, 5'd0);
                queue_byte(8'h00,               1'b1, 1'b0, 5'd0);
                queue_byte(lsf_pkg::ROW_END,    1'b1, 1'b1, 5'd0);
                queue_byte(lsf_pkg::OP_INVON,   1'b0, 1'b1, 5'd2);
                queue_byte(lsf_pkg::OP_NORON,   1'b0, 1'b1, 5'd2);
                queue_byte(lsf_pkg::OP_DISPON,  1'b0, 1'b1, 5'd2);
            end
            lsf_pkg::CMD_FULL:
                queue_byte(lsf_pkg::OP_RAMWR, 1'b0, 1'b0, 5'd0);
            lsf_pkg::CMD_WINDOW:
            begin
                queue_byte(lsf_pkg::OP_CASET, 1'b0, 1'b0, 5'd0);
                queue_byte(8'h00,             1'b1, 1'b0, 5'd0);
                queue_byte(r.x,               1'b1, 1'b0, 5'd0);
                queue_byte(8'h00,             1'b1, 1'b0, 5'd0);
                queue_byte(end_col,           1'b1, 1'b1, 5'd0);
                queue_byte(lsf_pkg::OP_RASET, 1'b0, 1'b0, 5'd0);
                queue_byte(8'h00,             1'b1, 1'b0, 5'd0);
                queue_byte(r.y,               1'b1, 1'b0, 5'd0);
                queue_byte(8'h00,             1'b1, 1'b0, 5'd0);
                queue_byte(lsf_pkg::ROW_END,  1'b1, 1'b1, 5'd0);
                queue_byte(lsf_pkg::OP_RAMWR, 1'b0, 1'b0, 5'd0);
            end
            lsf_pkg::CMD_PIXEL:
            begin
                if (r.high_first)
                begin
                    queue_byte(r.pixel[15:8], 1'b1, 1'b0, 5'd0);
                    queue_byte(r.pixel[7:0],  1'b1, 1'b0, 5'd0);
                end
                else
                begin
                    queue_byte(r.pixel[7:0],  1'b1, 1'b0, 5'd0);
                    queue_byte(r.pixel[15:8], 1'b1, 1'b0, 5'd0);
                end
            end
            lsf_pkg::CMD_CLOSE:
            begin
                // marker only: chip select and dc go up, no byte on the wire
                tail.data_byte    = 8'h00;
                tail.byte_valid   = 1'b0;
                tail.is_data      = 1'b1;
                tail.end_transfer = 1'b1;
                tail.wait_units   = 5'd0;
                tail.last         = 1'b0;
                spi_bytes_due.push_back(tail);
            end
            default:
                ;
        endcase
        if (spi_bytes_due.size() > queued)
        begin
            tail = spi_bytes_due.pop_back();
            tail.last = 1'b1;
            spi_bytes_due.push_back(tail);
        end
    endfunction

    function automatic lcd_req_t lcd_request(logic [2:0] cmd, logic [7:0] x, logic [7:0] y,
                                             logic [7:0] width, logic [15:0] pixel, logic hf);
        lcd_req_t r;
        r.cmd        = cmd;
        r.x          = x;
        r.y          = y;
        r.width      = width;
        r.pixel      = pixel;
        r.high_first = hf;
        return r;
    endfunction

    function automatic lcd_req_t rand_request(logic [2:0] cmd);
        return lcd_request(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 16'($urandom_range(65535)),
                           1'($urandom_range(1)));
    endfunction

    function automatic string item_text(lsf_pkg::item_t it);
        return $sformatf("byte %02h valid %0b dc %0b cs_up %0b wait %0d last %0b",
                         it.data_byte, it.byte_valid, it.is_data, it.end_transfer,
                         it.wait_units, it.last);
    endfunction

    function automatic void report_mismatch(string what, lsf_pkg::item_t want,
                                            lsf_pkg::item_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected %s, got %s", what, item_text(want), item_text(got));
    endfunction

    task automatic send_request(input lcd_req_t r);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, r.high_first, r.pixel, r.width, r.y, r.x};
        s_axis_tuser  <= r.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        frame_request(r);
        if (r.cmd <= lsf_pkg::CMD_CLOSE)
            requests_framed++;
    endtask

    task automatic test_boot_table();
        send_request(lcd_request(lsf_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
    endtask

    task automatic test_write_opens();
        send_request(lcd_request(lsf_pkg::CMD_FULL, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
        // zero width wraps the end column to 255
        send_request(lcd_request(lsf_pkg::CMD_WINDOW, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
        send_request(lcd_request(lsf_pkg::CMD_WINDOW, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
        send_request(lcd_request(lsf_pkg::CMD_WINDOW, 8'h00, 8'd239, 8'd240, 16'h1234, 1'b0));
        send_request(lcd_request(lsf_pkg::CMD_WINDOW, 8'd200, 8'd17, 8'd100, 16'h0000, 1'b1));
    endtask

    task automatic test_pixel_order();
        send_request(lcd_request(lsf_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1));
        send_request(lcd_request(lsf_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b0));
        send_request(lcd_request(lsf_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 16'hA55A, 1'b0));
        send_request(lcd_request(lsf_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00, 16'h5AA5, 1'b1));
    endtask

    task automatic test_close_marker();
        send_request(lcd_request(lsf_pkg::CMD_CLOSE, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
        send_request(lcd_request(lsf_pkg::CMD_CLOSE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
    endtask

    task automatic test_unused_codes();
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            send_request(rand_request(3'(c)));
        send_request(rand_request(lsf_pkg::CMD_CLOSE));
    endtask

    task automatic test_drain_pause();
        send_request(rand_request(lsf_pkg::CMD_WINDOW));
        repeat (3) send_request(rand_request(lsf_pkg::CMD_PIXEL));
        send_request(rand_request(lsf_pkg::CMD_CLOSE));
        // hold off until the framer has emptied out
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (spi_bytes_due.size() != 0)
            @(posedge clk);
        send_request(rand_request(lsf_pkg::CMD_FULL));
        send_request(rand_request(lsf_pkg::CMD_PIXEL));
        send_request(rand_request(lsf_pkg::CMD_CLOSE));
    endtask

    // mostly open / pixel run / close frames, with stray and unknown requests mixed in
    task automatic test_random_frames(input int count);
        int target;
        int pick;
        target = requests_framed + count;
        while (requests_framed < target)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                send_request(rand_request($urandom_range(1) ? lsf_pkg::CMD_WINDOW
                                                            : lsf_pkg::CMD_FULL));
                repeat ($urandom_range(1, 12)) send_request(rand_request(lsf_pkg::CMD_PIXEL));
                // now and then a frame is left open
                if ($urandom_range(9) != 0)
                    send_request(rand_request(lsf_pkg::CMD_CLOSE));
            end
            else if (pick < 92)
                send_request(rand_request(
                    3'($urandom_range(lsf_pkg::CMD_INIT, lsf_pkg::CMD_CLOSE))));
            else
                send_request(rand_request(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST))));
        end
    endtask

    always @(posedge clk)
    begin : spi_byte_check
        lsf_pkg::item_t got;
        lsf_pkg::item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data_byte    = m_axis_tdata[7:0];
            got.end_transfer = m_axis_tdata[8];
            got.wait_units   = m_axis_tdata[13:9];
            got.byte_valid   = m_axis_tuser[0];
            got.is_data      = m_axis_tuser[1];
            got.last         = m_axis_tlast;
            if (spi_bytes_due.size() == 0)
                report_mismatch("transfer with nothing pending", '0, got);
            else
            begin
                want = spi_bytes_due.pop_front();
                if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid ||
                    got.is_data !== want.is_data || got.end_transfer !== want.end_transfer ||
                    got.wait_units !== want.wait_units || got.last !== want.last)
                    report_mismatch("output mismatch", want, got);
            end
        end
        m_axis_tready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boot_table();
        test_write_opens();
        test_pixel_order();
        test_close_marker();
        test_unused_codes();
        test_drain_pause();
        test_random_frames(340);
        // long stretch with both sides running flat out
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_frames(120);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        s_axis_tvalid <= 1'b0;
        while (spi_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && spi_bytes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
